// ===== sv/assert_macros.svh =====
// Assertion macros for the RTL of the keyed quantity table.
// Define ASSERT_OFF to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/kqt_pkg.sv =====
// Package of the keyed quantity table: sizes, request and status codes,
// controller states and the command and status bundles. No dependencies.
`timescale 1ns / 1ps

package kqt_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int KEY_W = 32;
	localparam int QTY_W = 32;

	typedef logic [1:0] req_t;
	localparam req_t REQ_INSERT = 2'd0;
	localparam req_t REQ_SEARCH = 2'd1;
	localparam req_t REQ_UPDATE = 2'd2;

	typedef logic [1:0] stat_t;
	localparam stat_t ST_DONE      = 2'd0;
	localparam stat_t ST_NOT_FOUND = 2'd1;
	localparam stat_t ST_FULL      = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INSERT,
		S_READ,
		S_COMPARE,
		S_UPDATE,
		S_RESULT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_req;
		logic clr_idx;
		logic inc_idx;
		logic rd_en;
		logic do_insert;
		logic do_update;
		logic set_found;
		logic set_not_found;
		logic set_full;
		logic set_zero;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic empty;
		logic full;
		logic match;
		logic last;
		logic is_update;
	} dp_stat_t;

endpackage

// ===== sv/kqt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps

module kqt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/kqt_datapath.sv =====
// Datapath of the keyed quantity table: request registers, entry count, scan
// index, key and quantity memories, saturating adder and result registers.
// Depends on kqt_pkg and kqt_ram.
`timescale 1ns / 1ps

module kqt_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  kqt_pkg::cmd_t                 cmd,
	input  kqt_pkg::req_t                 req_type,
	input  logic signed [kqt_pkg::KEY_W-1:0] part_key,
	input  logic signed [kqt_pkg::QTY_W-1:0] quantity_value,
	output kqt_pkg::dp_stat_t             stat,
	output kqt_pkg::stat_t                status,
	output logic signed [kqt_pkg::QTY_W-1:0] found_quantity
);

	kqt_pkg::req_t                 kind_q;
	logic [kqt_pkg::KEY_W-1:0]     key_q;
	logic [kqt_pkg::QTY_W-1:0]     qv_q;
	logic [kqt_pkg::CNT_W-1:0]     count_q;
	logic [kqt_pkg::IDX_W-1:0]     idx_q;
	kqt_pkg::stat_t                status_q;
	logic [kqt_pkg::QTY_W-1:0]     qty_out_q;

	logic [kqt_pkg::KEY_W-1:0]     key_rdata;
	logic [kqt_pkg::QTY_W-1:0]     qty_rdata;
	logic [kqt_pkg::IDX_W-1:0]     waddr;
	logic [kqt_pkg::QTY_W-1:0]     qty_wdata;
	logic                          qty_we;
	logic signed [kqt_pkg::QTY_W:0] sum;
	logic [kqt_pkg::QTY_W-1:0]     sat_sum;
	logic [kqt_pkg::CNT_W-1:0]     idx_next;

	// One bit of headroom catches overflow in either direction.
	assign sum = $signed({qty_rdata[kqt_pkg::QTY_W-1], qty_rdata})
		+ $signed({qv_q[kqt_pkg::QTY_W-1], qv_q});

	always_comb begin
		priority if (sum[kqt_pkg::QTY_W] == 1'b0 && sum[kqt_pkg::QTY_W-1] == 1'b1) begin
			sat_sum = {1'b0, {(kqt_pkg::QTY_W-1){1'b1}}};
		end else if (sum[kqt_pkg::QTY_W] == 1'b1 && sum[kqt_pkg::QTY_W-1] == 1'b0) begin
			sat_sum = {1'b1, {(kqt_pkg::QTY_W-1){1'b0}}};
		end else begin
			sat_sum = sum[kqt_pkg::QTY_W-1:0];
		end
	end

	assign waddr     = cmd.do_insert ? count_q[kqt_pkg::IDX_W-1:0] : idx_q;
	assign qty_wdata = cmd.do_insert ? qv_q : sat_sum;
	assign qty_we    = cmd.do_insert | cmd.do_update;
	assign idx_next  = {{(kqt_pkg::CNT_W-kqt_pkg::IDX_W){1'b0}}, idx_q}
		+ kqt_pkg::CNT_W'(1);

	kqt_ram #(
		.WIDTH (kqt_pkg::KEY_W),
		.DEPTH (kqt_pkg::TABLE_DEPTH),
		.ADDR_W(kqt_pkg::IDX_W)
	) u_key_ram (
		.clk  (clk),
		.we   (cmd.do_insert),
		.waddr(waddr),
		.wdata(key_q),
		.re   (cmd.rd_en),
		.raddr(idx_q),
		.rdata(key_rdata)
	);

	kqt_ram #(
		.WIDTH (kqt_pkg::QTY_W),
		.DEPTH (kqt_pkg::TABLE_DEPTH),
		.ADDR_W(kqt_pkg::IDX_W)
	) u_qty_ram (
		.clk  (clk),
		.we   (qty_we),
		.waddr(waddr),
		.wdata(qty_wdata),
		.re   (cmd.rd_en),
		.raddr(idx_q),
		.rdata(qty_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			kind_q <= req_type;
			key_q  <= part_key;
			qv_q   <= quantity_value;
		end
		if (cmd.clr_idx) begin
			idx_q <= '0;
		end else if (cmd.inc_idx) begin
			idx_q <= idx_next[kqt_pkg::IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			status_q  <= kqt_pkg::ST_DONE;
			qty_out_q <= '0;
		end else begin
			if (cmd.do_insert) begin
				count_q <= count_q + kqt_pkg::CNT_W'(1);
			end
			priority if (cmd.do_update) begin
				status_q  <= kqt_pkg::ST_DONE;
				qty_out_q <= sat_sum;
			end else if (cmd.set_found) begin
				status_q  <= kqt_pkg::ST_DONE;
				qty_out_q <= qty_rdata;
			end else if (cmd.set_not_found) begin
				status_q  <= kqt_pkg::ST_NOT_FOUND;
				qty_out_q <= '0;
			end else if (cmd.set_full) begin
				status_q  <= kqt_pkg::ST_FULL;
				qty_out_q <= '0;
			end else if (cmd.do_insert || cmd.set_zero) begin
				status_q  <= kqt_pkg::ST_DONE;
				qty_out_q <= '0;
			end
		end
	end

	assign stat.empty     = (count_q == '0);
	assign stat.full      = (count_q == kqt_pkg::CNT_W'(kqt_pkg::TABLE_DEPTH));
	assign stat.match     = (key_rdata == key_q);
	assign stat.last      = (idx_next == count_q);
	assign stat.is_update = (kind_q == kqt_pkg::REQ_UPDATE);

	assign status         = status_q;
	assign found_quantity = qty_out_q;

endmodule

// ===== sv/kqt_controller.sv =====
// Controller of the keyed quantity table: sequences insert, scan, update and
// the result strobe. Depends on kqt_pkg.
`timescale 1ns / 1ps

module kqt_controller (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  kqt_pkg::req_t     req_type,
	input  kqt_pkg::dp_stat_t stat,
	output kqt_pkg::cmd_t     cmd,
	output logic              busy,
	output logic              done
);

	kqt_pkg::state_t state_q;
	kqt_pkg::state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kqt_pkg::S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			kqt_pkg::S_IDLE: begin
				if (start) begin
					unique case (req_type)
						kqt_pkg::REQ_INSERT: state_next = kqt_pkg::S_INSERT;
						kqt_pkg::REQ_SEARCH,
						kqt_pkg::REQ_UPDATE: begin
							state_next = stat.empty ? kqt_pkg::S_RESULT : kqt_pkg::S_READ;
						end
						default: state_next = kqt_pkg::S_RESULT;
					endcase
				end
			end
			kqt_pkg::S_INSERT: state_next = kqt_pkg::S_RESULT;
			kqt_pkg::S_READ:   state_next = kqt_pkg::S_COMPARE;
			kqt_pkg::S_COMPARE: begin
				priority if (stat.match) begin
					state_next = stat.is_update ? kqt_pkg::S_UPDATE : kqt_pkg::S_RESULT;
				end else if (stat.last) begin
					state_next = kqt_pkg::S_RESULT;
				end else begin
					state_next = kqt_pkg::S_READ;
				end
			end
			kqt_pkg::S_UPDATE: state_next = kqt_pkg::S_RESULT;
			kqt_pkg::S_RESULT: state_next = kqt_pkg::S_IDLE;
			default:           state_next = kqt_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		done = 1'b0;
		unique case (state_q)
			kqt_pkg::S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load_req = 1'b1;
					cmd.clr_idx  = 1'b1;
					unique case (req_type)
						kqt_pkg::REQ_INSERT: ;
						kqt_pkg::REQ_SEARCH,
						kqt_pkg::REQ_UPDATE: cmd.set_not_found = stat.empty;
						default:             cmd.set_zero = 1'b1;
					endcase
				end
			end
			kqt_pkg::S_INSERT: begin
				cmd.set_full  = stat.full;
				cmd.do_insert = !stat.full;
			end
			kqt_pkg::S_READ: cmd.rd_en = 1'b1;
			kqt_pkg::S_COMPARE: begin
				priority if (stat.match) begin
					cmd.set_found = !stat.is_update;
				end else if (stat.last) begin
					cmd.set_not_found = 1'b1;
				end else begin
					cmd.inc_idx = 1'b1;
				end
			end
			kqt_pkg::S_UPDATE: cmd.do_update = 1'b1;
			kqt_pkg::S_RESULT: done = 1'b1;
			default: ;
		endcase
	end

endmodule

// ===== sv/keyed_quantity_table.sv =====
// Keyed quantity table: insert, search and saturating update over up to
// TABLE_DEPTH key and quantity entries. Depends on kqt_pkg, kqt_controller,
// kqt_datapath and assert_macros.svh.
//
// A request is taken when start is high and busy is low; busy then stays high
// until the single result has been shown. The result appears on status and
// found_quantity for exactly one cycle with done high, and the receiver cannot
// stall it. An insert passes from the idle state through the insert state to
// the result state, and an unused request kind goes straight to the result
// state. A search or update walks the entries from the oldest, each through
// the read state, using the registered read port of the key and quantity
// memories, and then the compare state; an update that hits also writes the
// quantity back before the result, and a miss ends at the last stored entry,
// or at once on an empty table. The table needs no clearing pass after reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module keyed_quantity_table (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [1:0]                       req_type,
	input  logic signed [kqt_pkg::KEY_W-1:0] part_key,
	input  logic signed [kqt_pkg::QTY_W-1:0] quantity_value,
	output logic                             done,
	output logic [1:0]                       status,
	output logic signed [kqt_pkg::QTY_W-1:0] found_quantity
);

	kqt_pkg::cmd_t     cmd;
	kqt_pkg::dp_stat_t stat;

	kqt_controller u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req_type(req_type),
		.stat    (stat),
		.cmd     (cmd),
		.busy    (busy),
		.done    (done)
	);

	kqt_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.req_type      (req_type),
		.part_key      (part_key),
		.quantity_value(quantity_value),
		.stat          (stat),
		.status        (status),
		.found_quantity(found_quantity)
	);

	// A result is only ever shown while a request is in progress.
	`ASSERT_SAME(a_done_busy, clk, arst_n, done, busy)
	// An accepted request holds the block busy in the following cycle.
	`ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	// The result strobe lasts a single cycle and the block frees up after it.
	`ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done && !busy)
	// Anything but a successful lookup reports a zero quantity.
	`ASSERT_SAME(a_zero_qty, clk, arst_n, done && status != kqt_pkg::ST_DONE, found_quantity == '0)

endmodule

// ===== tb/sv/keyed_quantity_table_test.sv =====
// Self-checking testbench for keyed_quantity_table: a directed table of requests,
// then random request sequences under varied sender gaps, each result checked
// against a behavioural model or a fixed answer. Depends on kqt_pkg and the RTL.
`timescale 1ns / 1ps

module keyed_quantity_table_test;

	localparam kqt_pkg::req_t REQ_UNUSED = 2'd3;
	localparam int   KEY_POOL     = 40;
	localparam int   PHASE_ITEMS  = 483;
	localparam int   SETTLE_LIMIT = 160;

	typedef struct {
		kqt_pkg::stat_t st;
		logic [31:0]    qty;
	} answer_t;

	typedef struct {
		kqt_pkg::req_t  kind;
		logic [31:0]    key;
		logic [31:0]    qty;
		bit             typed;
		kqt_pkg::stat_t st;
		logic [31:0]    ans_qty;
	} dir_row_t;

	logic                             clk;
	logic                             arst_n;
	logic                             start;
	logic                             busy;
	logic [1:0]                       req_type;
	logic signed [kqt_pkg::KEY_W-1:0] part_key;
	logic signed [kqt_pkg::QTY_W-1:0] quantity_value;
	logic                             done;
	logic [1:0]                       status;
	logic signed [kqt_pkg::QTY_W-1:0] found_quantity;

	// Mirror of the table contents.
	logic [31:0]        key_mem [kqt_pkg::TABLE_DEPTH];
	logic signed [31:0] qty_mem [kqt_pkg::TABLE_DEPTH];
	int                 stored;

	answer_t     awaited_answers[$];
	dir_row_t    directed_rows[$];
	logic [31:0] key_pool [KEY_POOL];
	int          mismatches;
	int          idle_pct;

	keyed_quantity_table u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.req_type       (req_type),
		.part_key       (part_key),
		.quantity_value (quantity_value),
		.done           (done),
		.status         (status),
		.found_quantity (found_quantity)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic answer_t apply_request(input kqt_pkg::req_t kind,
			input logic [31:0] key, input logic signed [31:0] qty);
		answer_t a;
		int      hit;
		int      i;
		longint  sum;
		a.st = kqt_pkg::ST_DONE;
		a.qty = '0;
		hit = -1;
		if (kind == kqt_pkg::REQ_INSERT) begin
			if (stored < kqt_pkg::TABLE_DEPTH) begin
				key_mem[stored] = key;
				qty_mem[stored] = qty;
				stored++;
			end else begin
				a.st = kqt_pkg::ST_FULL;
			end
		end else if (kind == kqt_pkg::REQ_SEARCH || kind == kqt_pkg::REQ_UPDATE) begin
			// Only the oldest matching entry is seen.
			for (i = 0; i < stored && hit < 0; i++)
				if (key_mem[i] == key)
					hit = i;
			if (hit < 0) begin
				a.st = kqt_pkg::ST_NOT_FOUND;
			end else begin
				if (kind == kqt_pkg::REQ_UPDATE) begin
					sum = longint'(qty_mem[hit]) + longint'(qty);
					if (sum > 64'sd2147483647)
						sum = 64'sd2147483647;
					if (sum < -64'sd2147483648)
						sum = -64'sd2147483648;
					qty_mem[hit] = sum[31:0];
				end
				a.qty = qty_mem[hit];
			end
		end
		return a;
	endfunction

	function automatic void add_row(input kqt_pkg::req_t kind, input logic [31:0] key,
			input logic [31:0] qty, input bit typed, input kqt_pkg::stat_t st,
			input logic [31:0] ans_qty);
		dir_row_t row;
		row.kind = kind;
		row.key = key;
		row.qty = qty;
		row.typed = typed;
		row.st = st;
		row.ans_qty = ans_qty;
		directed_rows.push_back(row);
	endfunction

	function automatic logic [31:0] pick_quantity();
		logic [31:0] v;
		case ($urandom_range(9))
			0: v = 32'h7fff_ffff;
			1: v = 32'h8000_0000;
			2, 3: v = 32'($signed($urandom_range(200)) - 100);
			default: v = $urandom;
		endcase
		return v;
	endfunction

	task automatic note_failure(input string what);
		if (mismatches < 10)
			$display("%s", what);
		mismatches++;
	endtask

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic issue_request(input kqt_pkg::req_t kind, input logic [31:0] key,
			input logic [31:0] qty, input bit typed, input kqt_pkg::stat_t t_st,
			input logic [31:0] t_qty);
		answer_t ans;
		int      gap;
		if ($urandom_range(99) < idle_pct) begin
			gap = $urandom_range(1, 16);
			start <= 1'b0;
			repeat (gap) begin
				req_type <= 2'($urandom_range(3));
				part_key <= $urandom;
				quantity_value <= $urandom;
				@(negedge clk);
			end
		end
		start <= 1'b1;
		req_type <= kind;
		part_key <= key;
		quantity_value <= qty;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		ans = apply_request(kind, key, qty);
		if (typed) begin
			ans.st = t_st;
			ans.qty = t_qty;
		end
		awaited_answers.push_back(ans);
		@(negedge clk);
	endtask

	task automatic random_request();
		kqt_pkg::req_t kind;
		logic [31:0]   key;
		int            roll;
		roll = $urandom_range(99);
		if (roll < 15)
			kind = kqt_pkg::REQ_INSERT;
		else if (roll < 50)
			kind = kqt_pkg::REQ_SEARCH;
		else if (roll < 95)
			kind = kqt_pkg::REQ_UPDATE;
		else
			kind = REQ_UNUSED;
		// Lookups mostly aim at stored keys, so that deep entries are reached.
		if (kind != kqt_pkg::REQ_INSERT && stored > 0 && $urandom_range(1) == 1)
			key = key_mem[$urandom_range(stored - 1)];
		else if ($urandom_range(9) < 8)
			key = key_pool[$urandom_range(KEY_POOL - 1)];
		else
			key = $urandom;
		issue_request(kind, key, pick_quantity(), 1'b0, kqt_pkg::ST_DONE, '0);
	endtask

	always @(posedge clk) begin : result_check
		answer_t want;
		if (arst_n && done) begin
			if (awaited_answers.size() == 0) begin
				note_failure($sformatf("unexpected result: status %0d qty %h",
					status, found_quantity));
			end else begin
				want = awaited_answers.pop_front();
				if (status !== want.st || found_quantity !== want.qty)
					note_failure($sformatf(
						"mismatch: expected status %0d qty %h, got status %0d qty %h",
						want.st, want.qty, status, found_quantity));
			end
		end
	end

	initial begin
		#20_000_000;
		$display("keyed_quantity_table test failed");
		$finish;
	end

	initial begin
		int i;
		int phase;
		int waited;
		arst_n = 1'b0;
		start = 1'b0;
		req_type = '0;
		part_key = '0;
		quantity_value = '0;
		stored = 0;
		mismatches = 0;
		idle_pct = 0;
		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7fff_ffff;
		key_pool[2] = 32'h0000_0000;
		key_pool[3] = 32'hffff_ffff;
		for (i = 4; i < KEY_POOL; i++)
			key_pool[i] = $urandom;

		// Empty table, unused kind, extreme keys and quantities, duplicates,
		// saturation both ways and a missing key.
		add_row(kqt_pkg::REQ_SEARCH, 32'h0, 32'h0, 1, kqt_pkg::ST_NOT_FOUND, '0);
		add_row(kqt_pkg::REQ_UPDATE, 32'h0, 32'h5, 1, kqt_pkg::ST_NOT_FOUND, '0);
		add_row(REQ_UNUSED, 32'h0, 32'h0, 1, kqt_pkg::ST_DONE, '0);
		add_row(kqt_pkg::REQ_INSERT, 32'h8000_0000, 32'h7fff_ffff, 1, kqt_pkg::ST_DONE, '0);
		add_row(kqt_pkg::REQ_INSERT, 32'h7fff_ffff, 32'h8000_0000, 1, kqt_pkg::ST_DONE, '0);
		add_row(kqt_pkg::REQ_INSERT, 32'h0, 32'h0, 1, kqt_pkg::ST_DONE, '0);
		add_row(kqt_pkg::REQ_INSERT, 32'hffff_ffff, 32'h5, 1, kqt_pkg::ST_DONE, '0);
		add_row(kqt_pkg::REQ_INSERT, 32'h0, 32'd99, 1, kqt_pkg::ST_DONE, '0);
		add_row(kqt_pkg::REQ_SEARCH, 32'h0, 32'hffff_ffff, 0, kqt_pkg::ST_DONE, '0);
		add_row(kqt_pkg::REQ_UPDATE, 32'h8000_0000, 32'h1, 1, kqt_pkg::ST_DONE,
			32'h7fff_ffff);
		add_row(kqt_pkg::REQ_UPDATE, 32'h7fff_ffff, 32'hffff_ffff, 1, kqt_pkg::ST_DONE,
			32'h8000_0000);
		add_row(kqt_pkg::REQ_UPDATE, 32'h0, 32'h7fff_ffff, 0, kqt_pkg::ST_DONE, '0);
		add_row(kqt_pkg::REQ_SEARCH, 32'h0, 32'h0, 0, kqt_pkg::ST_DONE, '0);
		add_row(kqt_pkg::REQ_UPDATE, 32'h0, 32'h8000_0000, 0, kqt_pkg::ST_DONE, '0);
		add_row(kqt_pkg::REQ_UPDATE, 32'hffff_ffff, 32'h0, 0, kqt_pkg::ST_DONE, '0);
		add_row(kqt_pkg::REQ_SEARCH, 32'hffff_ffff, 32'h1234_5678, 0, kqt_pkg::ST_DONE, '0);
		add_row(kqt_pkg::REQ_SEARCH, 32'h0001_2345, 32'h0, 1, kqt_pkg::ST_NOT_FOUND, '0);
		add_row(kqt_pkg::REQ_UPDATE, 32'h8000_0000, 32'h8000_0000, 0, kqt_pkg::ST_DONE, '0);
		add_row(REQ_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 1, kqt_pkg::ST_DONE, '0);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			issue_request(directed_rows[i].kind, directed_rows[i].key,
				directed_rows[i].qty, directed_rows[i].typed,
				directed_rows[i].st, directed_rows[i].ans_qty);

		// The receiver cannot stall; the first and third phases run without sender gaps.
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: idle_pct = 0;
				1: idle_pct = 45;
				2: idle_pct = 0;
				default: idle_pct = 32;
			endcase
			repeat (PHASE_ITEMS)
				random_request();
		end
		start <= 1'b0;

		while (awaited_answers.size() != 0)
			@(posedge clk);
		waited = 0;
		while (waited < SETTLE_LIMIT) begin
			@(posedge clk);
			waited++;
		end

		if (mismatches == 0 && awaited_answers.size() == 0)
			$display("keyed_quantity_table test passed");
		else
			$display("keyed_quantity_table test failed");
		$finish;
	end

endmodule
